FILE: design/pnesc_pkg.sv
// Package: shared types, character constants and helper functions for the name escape encoder.
`default_nettype none
package pnesc_pkg;

    localparam logic [7:0] CH_LOW_LIMIT  = 8'd32;
    localparam logic [7:0] CH_HIGH_LIMIT = 8'd96;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_OPEN       = 8'h7B;
    localparam logic [7:0] CH_CLOSE      = 8'h7D;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_TERM       = 8'h00;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    localparam logic [8:0] ESC_ROOM   = 9'd4;
    localparam logic [8:0] PLAIN_ROOM = 9'd2;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // One queued job: up to three characters, emitted from index 0 up to last_idx.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            is_end;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    function automatic logic needs_escape(input logic [7:0] c);
        logic r;
        r = (c < CH_LOW_LIMIT) || (c >= CH_HIGH_LIMIT) ||
            (c == CH_COLON) || (c == CH_SLASH) || (c == CH_BACKSLASH) ||
            (c == CH_DQUOTE) || (c == CH_COMMA) || (c == CH_LESS) ||
            (c == CH_GREATER);
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else begin
            r = 8'h37 + {4'd0, d};
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c | CASE_BIT;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/pnesc_in_if.sv
// Interface: input channel carrying name bytes and the end command.
`default_nettype none
interface pnesc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface
`default_nettype wire

FILE: design/pnesc_out_if.sv
// Interface: output channel carrying encoded characters.
`default_nettype none
interface pnesc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

FILE: design/pnesc_front.sv
// Front end: accepts input items, tracks group/length state and builds character jobs.
`default_nettype none
module pnesc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_cmd,
    input  wire logic [7:0]      i_char_in,
    input  wire logic            i_queue_full,
    input  wire logic            i_cfg_we,
    input  wire logic [7:0]      i_cfg_wdata,
    output logic                 o_ready,
    output pnesc_pkg::t_push     o_push
);
    import pnesc_pkg::*;

    logic [7:0] r_max_length;
    logic       r_group_open, n_group_open;
    logic [7:0] r_out_count,  n_out_count;
    logic       r_stopped,    n_stopped;

    logic       accept;
    logic       esc;
    logic [8:0] used;
    logic [8:0] limit;
    t_job       job;
    logic       produce;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign esc     = needs_escape(i_char_in);
    assign used    = {1'b0, r_out_count};
    assign limit   = {1'b0, r_max_length};

    always_comb begin
        job          = '0;
        produce      = 1'b0;
        n_group_open = r_group_open;
        n_out_count  = r_out_count;
        n_stopped    = r_stopped;
        if (i_cmd == CMD_END) begin
            // close any open group, then the terminator; clear state
            produce      = 1'b1;
            job.is_end   = 1'b1;
            if (r_group_open) begin
                job.chars[0] = CH_CLOSE;
                job.chars[1] = CH_TERM;
                job.last_idx = 2'd1;
            end else begin
                job.chars[0] = CH_TERM;
                job.last_idx = 2'd0;
            end
            n_group_open = 1'b0;
            n_out_count  = '0;
            n_stopped    = 1'b0;
        end else if (!r_stopped) begin
            if (esc) begin
                if (used + ESC_ROOM >= limit) begin
                    n_stopped = 1'b1;
                end else begin
                    produce = 1'b1;
                    if (!r_group_open) begin
                        job.chars[0] = CH_OPEN;
                        job.chars[1] = hex_digit(i_char_in[7:4]);
                        job.chars[2] = hex_digit(i_char_in[3:0]);
                        job.last_idx = 2'd2;
                        n_out_count  = r_out_count + 8'd3;
                    end else begin
                        job.chars[0] = hex_digit(i_char_in[7:4]);
                        job.chars[1] = hex_digit(i_char_in[3:0]);
                        job.last_idx = 2'd1;
                        n_out_count  = r_out_count + 8'd2;
                    end
                    n_group_open = 1'b1;
                end
            end else begin
                if (used + PLAIN_ROOM >= limit) begin
                    n_stopped = 1'b1;
                end else begin
                    produce = 1'b1;
                    if (r_group_open) begin
                        job.chars[0] = CH_CLOSE;
                        job.chars[1] = to_lower(i_char_in);
                        job.last_idx = 2'd1;
                        n_out_count  = r_out_count + 8'd2;
                    end else begin
                        job.chars[0] = to_lower(i_char_in);
                        job.last_idx = 2'd0;
                        n_out_count  = r_out_count + 8'd1;
                    end
                    n_group_open = 1'b0;
                end
            end
        end
    end

    assign o_push.valid = accept && produce;
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
            r_group_open <= 1'b0;
            r_out_count  <= '0;
            r_stopped    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_length <= i_cfg_wdata;
            end
            if (accept) begin
                r_group_open <= n_group_open;
                r_out_count  <= n_out_count;
                r_stopped    <= n_stopped;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/pnesc_queue.sv
// Job queue: small register FIFO between the front end and the character emitter.
`default_nettype none
module pnesc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pnesc_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_head_valid,
    output pnesc_pkg::t_job      o_head
);
    import pnesc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_ONE;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_ONE;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_ONE;
                2'b01:   r_cnt <= r_cnt - CNT_ONE;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/pnesc_back.sv
// Back end: walks the head job one character per cycle, while the output is not stalled, into the output register.
`default_nettype none
module pnesc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_head_valid,
    input  wire pnesc_pkg::t_job i_head,
    input  wire logic            i_out_ready,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_out_last
);
    import pnesc_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic load;
    logic at_end;

    assign load   = !r_out_valid || i_out_ready;
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && i_head_valid && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                // advance through the job, drop it after its final character
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_out_char <= i_head.chars[r_idx];
            r_out_last <= i_head.is_end && at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

FILE: design/petscii_name_escape_encoder.sv
// Top level: name escape encoder with decoupled front end, job queue and emitter.
//
//   channel   dir  handshake        payload
//   i_in      in   valid/ready      cmd[0], char_in[7:0]
//   o_out     out  valid/ready      out_char[7:0], last
//   i_cfg_*   in   write enable     max_length[7:0]
//
// Each accepted item yields zero to three characters; the emitter sends one per
// cycle while the output is ready, from the single-character output register.
// The front end accepts an item in any cycle the job queue has room, so it
// runs ahead of a stalled output.
// Reset is synchronous, active low; no clearing pass.
`default_nettype none
module petscii_name_escape_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pnesc_in_if.sink        i_in,
    pnesc_out_if.source     o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);
    import pnesc_pkg::*;

    t_push push;
    t_job  head;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    pnesc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_cmd        (i_in.cmd),
        .i_char_in    (i_in.char_in),
        .i_queue_full (queue_full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_ready      (i_in.ready),
        .o_push       (push)
    );

    pnesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    pnesc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_out_ready  (o_out.ready),
        .o_pop        (pop),
        .o_out_valid  (o_out.valid),
        .o_out_char   (o_out.out_char),
        .o_out_last   (o_out.last)
    );

endmodule
`default_nettype wire
